// File: design/xmodem_checksum_receiver_macros.svh
// ---------------------------------------------------------------------------
// XMODEM checksum receiver assertion macros
// Shared property wrappers for the port checker.
// ---------------------------------------------------------------------------
`ifndef XMODEM_CHECKSUM_RECEIVER_MACROS_SVH
`define XMODEM_CHECKSUM_RECEIVER_MACROS_SVH

// Check a property outside reset
`define XMCK_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property at every edge, reset included
`define XMCK_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/xmck_pkg.sv
// ---------------------------------------------------------------------------
// xmck_pkg
// Control characters, result kinds and the result word for the XMODEM
// checksum receiver.
// ---------------------------------------------------------------------------
package xmck_pkg;

    // Line control characters
    localparam logic [7:0] CH_SOH = 8'h01;
    localparam logic [7:0] CH_EOT = 8'h04;
    localparam logic [7:0] CH_ACK = 8'h06;
    localparam logic [7:0] CH_NAK = 8'h15;
    localparam logic [7:0] CH_CAN = 8'h18;
    localparam logic [7:0] NUM_CHECK = 8'hff;

    // NAK interval register
    localparam int unsigned WAIT_W = 22;
    localparam logic [WAIT_W-1:0] NAK_INTERVAL_RESET = 22'd2000000;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_SEND   = 2'd0,
        KIND_STORE  = 2'd1,
        KIND_FINISH = 2'd2,
        KIND_ABORT  = 2'd3
    } kind_t;

    // One queued result; pair marks an ACK that is followed by a finish word
    typedef struct packed {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [15:0] store_addr;
        logic [7:0]  store_data;
        logic [16:0] total_size;
        logic        pair;
    } result_t;

endpackage

// File: design/xmodem_checksum_receiver.sv
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver
// Receiving side of XMODEM with an 8-bit checksum.
// ---------------------------------------------------------------------------
// Takes one word per clock: a received byte (tuser 0) or an idle tick
// (tuser 1). A word waits in the input register, where it is
// decoded against the protocol state, and then waits in a two-entry result
// queue. Every word gives at most one queue entry, so a new word enters each
// cycle as long as the queue drains; s_axis_tready drops only when the input
// register and both queue entries are held and the head entry does not leave
// in that cycle, either because the master side stalls or because the head
// is the ACK word of an EOT. EOT leaves as two words (ACK, then finish).
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver
    import xmck_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES  = 128,
    parameter int unsigned BUFFER_BYTES = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    // Configuration: NAK interval in ticks
    input  logic              cfg_we,
    input  logic [WAIT_W-1:0] cfg_wdata,
    // Input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    input  logic              s_axis_tuser,   // [0] op
    // Result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [55:0]       m_axis_tdata,   // [7:0] tx_byte, [23:8] store_addr,
                                              // [31:24] store_data, [48:32] total_size
    output logic [1:0]        m_axis_tuser,   // [1:0] kind
    output logic              m_axis_tlast
);

    logic    q_room;
    logic    push;
    result_t res;
    result_t out_res;

    // Decode words against the protocol state
    xmck_proto #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_proto (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_byte   (s_axis_tdata),
        .in_ready  (s_axis_tready),
        .q_room    (q_room),
        .push      (push),
        .res       (res)
    );

    // Buffer results toward the master side
    xmck_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_res  (res),
        .room      (q_room),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_res   (out_res),
        .out_last  (m_axis_tlast)
    );

    // Pack the result word
    assign m_axis_tdata = {7'b0, out_res.total_size, out_res.store_data,
                           out_res.store_addr, out_res.tx_byte};
    assign m_axis_tuser = out_res.kind;

endmodule

// File: design/xmck_proto.sv
// ---------------------------------------------------------------------------
// xmck_proto
// Input register and protocol state: one item is decoded per cycle while the
// queue has room, and any result is handed to the output queue.
// ---------------------------------------------------------------------------
module xmck_proto
    import xmck_pkg::*;
#(
    parameter int unsigned BLOCK_BYTES  = 128,
    parameter int unsigned BUFFER_BYTES = 65536
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [WAIT_W-1:0] cfg_wdata,
    input  logic              in_valid,
    input  logic              in_op,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    input  logic              q_room,
    output logic              push,
    output result_t           res
);

    localparam int unsigned IDX_W  = $clog2(BLOCK_BYTES);
    localparam int unsigned ADDR_W = $clog2(BUFFER_BYTES);
    localparam int unsigned SIZE_W = $clog2(BUFFER_BYTES + 1);

    localparam logic [ADDR_W:0]   BUF_LIM  = (ADDR_W + 1)'(BUFFER_BYTES);
    localparam logic [ADDR_W:0]   BLK_ADD  = (ADDR_W + 1)'(BLOCK_BYTES);
    localparam logic [SIZE_W:0]   SIZE_LIM = (SIZE_W + 1)'(BUFFER_BYTES);
    localparam logic [SIZE_W:0]   SIZE_ADD = (SIZE_W + 1)'(BLOCK_BYTES);
    localparam logic [SIZE_W-1:0] SIZE_MAX = SIZE_W'(BUFFER_BYTES);
    localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(BLOCK_BYTES - 1);

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_NUMBER,
        PH_INVERSE,
        PH_DATA,
        PH_SUM
    } phase_t;

    // Input register
    logic              hold_valid_reg, hold_valid_next;
    logic              hold_op_reg;
    logic [7:0]        hold_byte_reg;

    // Protocol state
    logic [WAIT_W-1:0] nak_interval_reg, nak_interval_next;
    phase_t            phase_reg, phase_next;
    logic              receiving_reg, receiving_next;
    logic [7:0]        expected_reg, expected_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic [7:0]        sum_reg, sum_next;
    logic [7:0]        check_reg, check_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [WAIT_W-1:0] wait_reg, wait_next;

    logic              step;
    logic              in_take;
    logic [ADDR_W:0]   addr_sum, addr_mod, base_sum, base_mod;
    logic [SIZE_W:0]   size_sum;
    logic [SIZE_W-1:0] size_upd;
    logic [WAIT_W-1:0] wait_inc;
    logic [7:0]        sum_add;
    logic [ADDR_W+15:0] addr_wide;
    logic [SIZE_W+16:0] size_wide;
    logic [SIZE_W-1:0] size_out;

    // Handshake: the held item moves on whenever the queue can take it
    assign step     = hold_valid_reg && q_room;
    assign in_ready = !hold_valid_reg || q_room;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (in_take)
        begin
            hold_valid_next = 1'b1;
        end
        else if (step)
        begin
            hold_valid_next = 1'b0;
        end
        else
        begin
            hold_valid_next = hold_valid_reg;
        end
    end

    // Datapath arithmetic
    assign addr_sum = {1'b0, base_reg} + (ADDR_W + 1)'(idx_reg);
    assign addr_mod = (addr_sum >= BUF_LIM) ? addr_sum - BUF_LIM : addr_sum;
    assign base_sum = {1'b0, base_reg} + BLK_ADD;
    assign base_mod = (base_sum >= BUF_LIM) ? base_sum - BUF_LIM : base_sum;
    assign size_sum = {1'b0, size_reg} + SIZE_ADD;
    assign size_upd = (size_sum >= SIZE_LIM) ? SIZE_MAX : size_sum[SIZE_W-1:0];
    assign wait_inc = wait_reg + WAIT_W'(1);
    assign sum_add  = sum_reg + hold_byte_reg;

    // Fit internal address and size to the port widths
    assign addr_wide = {16'b0, addr_mod[ADDR_W-1:0]};
    assign size_wide = {17'b0, size_out};

    // Decode the held item
    always_comb
    begin
        nak_interval_next = cfg_we ? cfg_wdata : nak_interval_reg;
        phase_next        = phase_reg;
        receiving_next    = receiving_reg;
        expected_next     = expected_reg;
        idx_next          = idx_reg;
        sum_next          = sum_reg;
        check_next        = check_reg;
        base_next         = base_reg;
        size_next         = size_reg;
        wait_next         = wait_reg;
        size_out          = size_reg;
        push              = 1'b0;
        res               = '0;
        res.kind          = KIND_SEND;

        if (step)
        begin
            if (hold_op_reg)
            begin
                // Idle tick: count toward a NAK until the first block starts
                if (phase_reg == PH_HEADER && !receiving_reg)
                begin
                    if (wait_inc >= nak_interval_reg)
                    begin
                        wait_next   = '0;
                        push        = 1'b1;
                        res.tx_byte = CH_NAK;
                    end
                    else
                    begin
                        wait_next = wait_inc;
                    end
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_NUMBER:
                    begin
                        if (hold_byte_reg != expected_reg)
                        begin
                            phase_next  = PH_HEADER;
                            push        = 1'b1;
                            res.tx_byte = CH_NAK;
                        end
                        else
                        begin
                            check_next = hold_byte_reg;
                            phase_next = PH_INVERSE;
                        end
                    end
                    PH_INVERSE:
                    begin
                        if ((check_reg ^ hold_byte_reg) != NUM_CHECK)
                        begin
                            phase_next  = PH_HEADER;
                            push        = 1'b1;
                            res.tx_byte = CH_NAK;
                        end
                        else
                        begin
                            idx_next   = '0;
                            sum_next   = '0;
                            phase_next = PH_DATA;
                        end
                    end
                    PH_DATA:
                    begin
                        sum_next = sum_add;
                        if (idx_reg == IDX_LAST)
                        begin
                            idx_next   = '0;
                            phase_next = PH_SUM;
                        end
                        else
                        begin
                            idx_next = idx_reg + IDX_W'(1);
                        end
                        push           = 1'b1;
                        res.kind       = KIND_STORE;
                        res.store_addr = addr_wide[15:0];
                        res.store_data = hold_byte_reg;
                    end
                    PH_SUM:
                    begin
                        phase_next = PH_HEADER;
                        push       = 1'b1;
                        if (sum_reg != hold_byte_reg)
                        begin
                            res.tx_byte = CH_NAK;
                        end
                        else
                        begin
                            expected_next = expected_reg + 8'd1;
                            base_next     = base_mod[ADDR_W-1:0];
                            size_next     = size_upd;
                            size_out      = size_upd;
                            res.tx_byte   = CH_ACK;
                        end
                    end
                    default:
                    begin
                        // Header byte; unused phase codes land here too
                        phase_next = PH_HEADER;
                        wait_next  = '0;
                        if (hold_byte_reg == CH_EOT)
                        begin
                            push        = 1'b1;
                            res.tx_byte = CH_ACK;
                            res.pair    = 1'b1;
                        end
                        else if (hold_byte_reg == CH_CAN || (hold_byte_reg != CH_SOH
                                 && receiving_reg))
                        begin
                            push     = 1'b1;
                            res.kind = KIND_ABORT;
                        end
                        else if (hold_byte_reg == CH_SOH)
                        begin
                            receiving_next = 1'b1;
                            phase_next     = PH_NUMBER;
                        end

                        // Finish and abort drop the transfer state
                        if (push)
                        begin
                            phase_next     = PH_HEADER;
                            receiving_next = 1'b0;
                            expected_next  = 8'd1;
                            idx_next       = '0;
                            sum_next       = '0;
                            check_next     = '0;
                            base_next      = '0;
                            size_next      = '0;
                            wait_next      = '0;
                        end
                    end
                endcase
            end
        end

        res.total_size = size_wide[16:0];
    end

    // Hold state and input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg   <= 1'b0;
            nak_interval_reg <= NAK_INTERVAL_RESET;
            phase_reg        <= PH_HEADER;
            receiving_reg    <= 1'b0;
            expected_reg     <= 8'd1;
            idx_reg          <= '0;
            sum_reg          <= '0;
            check_reg        <= '0;
            base_reg         <= '0;
            size_reg         <= '0;
            wait_reg         <= '0;
        end
        else
        begin
            hold_valid_reg   <= hold_valid_next;
            nak_interval_reg <= nak_interval_next;
            phase_reg        <= phase_next;
            receiving_reg    <= receiving_next;
            expected_reg     <= expected_next;
            idx_reg          <= idx_next;
            sum_reg          <= sum_next;
            check_reg        <= check_next;
            base_reg         <= base_next;
            size_reg         <= size_next;
            wait_reg         <= wait_next;
        end
    end

    // Payload of the input register
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            hold_op_reg   <= in_op;
            hold_byte_reg <= in_byte;
        end
    end

endmodule

// File: design/xmck_outq.sv
// ---------------------------------------------------------------------------
// xmck_outq
// Two-entry result queue; an entry marked as a pair leaves as an ACK word
// followed by a finish word.
// ---------------------------------------------------------------------------
module xmck_outq
    import xmck_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_res,
    output logic    room,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_res,
    output logic    out_last
);

    localparam int unsigned DEPTH = 2;

    result_t                   entry_reg [DEPTH];
    logic                      wr_ptr_reg, wr_ptr_next;
    logic                      rd_ptr_reg, rd_ptr_next;
    logic [$clog2(DEPTH+1)-1:0] count_reg, count_next;
    logic                      sub_reg, sub_next;
    logic                      beat;
    logic                      pop;
    result_t                   head;

    assign head      = entry_reg[rd_ptr_reg];
    assign out_valid = (count_reg != '0);
    assign beat      = out_valid && out_ready;
    assign pop       = beat && (!head.pair || sub_reg);
    assign room      = (count_reg != DEPTH[$clog2(DEPTH+1)-1:0]) || pop;

    // Shape the outgoing word
    always_comb
    begin
        out_res      = head;
        out_res.pair = 1'b0;
        out_last     = !head.pair || sub_reg;
        if (head.pair && sub_reg)
        begin
            out_res.kind       = KIND_FINISH;
            out_res.tx_byte    = '0;
            out_res.store_addr = '0;
            out_res.store_data = '0;
        end
    end

    // Advance pointers and count
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        sub_next    = beat ? (head.pair && !sub_reg) : sub_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
            sub_reg    <= 1'b0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            sub_reg    <= sub_next;
        end
    end

    // Store pushed results
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_res;
        end
    end

endmodule

// File: design/xmck_checker.sv
// ---------------------------------------------------------------------------
// xmck_checker
// Port-level checks on the result stream of the XMODEM checksum receiver.
// ---------------------------------------------------------------------------
`include "xmodem_checksum_receiver_macros.svh"

module xmck_checker
    import xmck_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [55:0] m_axis_tdata,
    input  logic [1:0]  m_axis_tuser,
    input  logic        m_axis_tlast
);

    // Hold a stalled word
    `XMCK_ASSERT(a_stall_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result word changed while stalled")

    // Only the ACK of an EOT is not the last word of its item
    `XMCK_ASSERT(a_open_is_ack, m_axis_tvalid && !m_axis_tlast |-> m_axis_tuser == KIND_SEND && m_axis_tdata[7:0] == CH_ACK, "non-last word is not an ACK")

    // The finish word follows the EOT ACK at once
    `XMCK_ASSERT(a_finish_follows, m_axis_tvalid && m_axis_tready && !m_axis_tlast |=> m_axis_tvalid && m_axis_tlast && m_axis_tuser == KIND_FINISH, "finish word missing after EOT ACK")

    // Store words carry no control byte
    `XMCK_ASSERT(a_store_clean, m_axis_tvalid && m_axis_tuser == KIND_STORE |-> m_axis_tlast && m_axis_tdata[7:0] == 8'h00, "store word malformed")

    // Drop output during reset
    `XMCK_ASSERT_ALWAYS(a_reset_idle, !rst_n |-> !m_axis_tvalid, "result valid during reset")

endmodule

bind xmodem_checksum_receiver xmck_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: tb/xmodem_checksum_receiver_tb.sv
// ---------------------------------------------------------------------------
// xmodem_checksum_receiver_tb
// Drives received bytes and idle ticks into the XMODEM checksum receiver and
// checks every result word against a cycle-free model of the protocol.
// A short scripted part covers ticks, control bytes and header errors; random
// traffic then mixes good and damaged blocks, and a final transfer, mostly of
// good blocks, runs while the result side is held off for a long stretch.
// ---------------------------------------------------------------------------
module xmodem_checksum_receiver_tb;
    import xmck_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned BLOCK_BYTES  = 128;
    localparam int unsigned BUFFER_BYTES = 65536;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          DRAIN_CYCLES  = 10;
    localparam int          HOLD_CYCLES   = 200;
    localparam int          LIMIT_NS      = 3000000;

    typedef enum logic [2:0] {
        WAIT_HEADER,
        GET_NUMBER,
        GET_INVERSE,
        GET_DATA,
        GET_SUM
    } rx_phase_t;

    typedef enum int {
        FLAW_NONE,
        FLAW_NUMBER,
        FLAW_INVERSE,
        FLAW_SUM,
        FLAW_SHORT
    } block_flaw_t;

    typedef enum int {
        RX_ALWAYS,
        RX_PATTERN,
        RX_RANDOM,
        RX_SPARSE
    } rx_mode_t;

    typedef struct {
        kind_t       kind;
        logic [7:0]  tx_byte;
        logic [15:0] store_addr;
        logic [7:0]  store_data;
        logic [16:0] total_size;
        logic        last;
    } rx_word_t;

    // One scripted step: an interval write, or a word with an optional
    // hand-written expectation (word_count < 0 leaves it to the model)
    typedef struct {
        bit          is_cfg;
        logic [21:0] interval;
        logic        op;
        logic [7:0]  value;
        int          word_count;
        kind_t       first_kind;
        logic [7:0]  first_tx;
        kind_t       second_kind;
    } script_row_t;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [WAIT_W-1:0] cfg_wdata;
    logic              s_axis_tvalid;
    logic              s_axis_tready;
    logic [7:0]        s_axis_tdata;
    logic              s_axis_tuser;
    logic              m_axis_tvalid;
    logic              m_axis_tready;
    logic [55:0]       m_axis_tdata;
    logic [1:0]        m_axis_tuser;
    logic              m_axis_tlast;

    // Protocol model state
    rx_phase_t         rcv_phase;
    logic              in_transfer;
    logic [7:0]        next_block;
    int                data_index;
    logic [7:0]        data_sum;
    logic [7:0]        number_seen;
    logic [15:0]       base_addr;
    logic [16:0]       size_total;
    logic [21:0]       tick_count;
    logic [21:0]       nak_ticks;

    rx_word_t          step_words[$];
    rx_word_t          table_words[$];
    rx_word_t          due_words[$];
    script_row_t       directed_rows[$];

    int                failures = 0;
    int                burst_left = 0;
    int                byte_count = 0;
    bit                hold_req = 1'b0;

    xmodem_checksum_receiver #(
        .BLOCK_BYTES  (BLOCK_BYTES),
        .BUFFER_BYTES (BUFFER_BYTES)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // -----------------------------------------------------------------------
    // Protocol model
    // -----------------------------------------------------------------------
    task automatic restart_transfer();
        rcv_phase   = WAIT_HEADER;
        in_transfer = 1'b0;
        next_block  = 8'd1;
        data_index  = 0;
        data_sum    = '0;
        number_seen = '0;
        base_addr   = '0;
        size_total  = '0;
        tick_count  = '0;
    endtask

    task automatic push_word(input kind_t kind, input logic [7:0] tx,
                             input logic [15:0] addr, input logic [7:0] data,
                             input logic last);
        rx_word_t w;
        w.kind       = kind;
        w.tx_byte    = tx;
        w.store_addr = addr;
        w.store_data = data;
        w.total_size = size_total;
        w.last       = last;
        step_words.push_back(w);
    endtask

    // Advance the model by one accepted word and collect its result words
    task automatic predict_receiver_words(input logic op, input logic [7:0] value);
        logic [15:0] addr;
        step_words.delete();
        if (op == 1'b1)
        begin
            // count idle time only while waiting for the first block
            if (rcv_phase == WAIT_HEADER && !in_transfer)
            begin
                tick_count = tick_count + 22'd1;
                if (tick_count >= nak_ticks)
                begin
                    tick_count = '0;
                    push_word(KIND_SEND, CH_NAK, '0, '0, 1'b1);
                end
            end
        end
        else
        begin
            case (rcv_phase)
                GET_NUMBER:
                begin
                    if (value != next_block)
                    begin
                        rcv_phase = WAIT_HEADER;
                        push_word(KIND_SEND, CH_NAK, '0, '0, 1'b1);
                    end
                    else
                    begin
                        number_seen = value;
                        rcv_phase   = GET_INVERSE;
                    end
                end
                GET_INVERSE:
                begin
                    if ((number_seen ^ value) != NUM_CHECK)
                    begin
                        rcv_phase = WAIT_HEADER;
                        push_word(KIND_SEND, CH_NAK, '0, '0, 1'b1);
                    end
                    else
                    begin
                        data_index = 0;
                        data_sum   = '0;
                        rcv_phase  = GET_DATA;
                    end
                end
                GET_DATA:
                begin
                    addr       = 16'((int'(base_addr) + data_index) % BUFFER_BYTES);
                    data_sum   = data_sum + value;
                    data_index = data_index + 1;
                    if (data_index >= BLOCK_BYTES)
                    begin
                        data_index = 0;
                        rcv_phase  = GET_SUM;
                    end
                    push_word(KIND_STORE, '0, addr, value, 1'b1);
                end
                GET_SUM:
                begin
                    rcv_phase = WAIT_HEADER;
                    if (data_sum != value)
                        push_word(KIND_SEND, CH_NAK, '0, '0, 1'b1);
                    else
                    begin
                        next_block = next_block + 8'd1;
                        base_addr  = 16'((int'(base_addr) + BLOCK_BYTES) % BUFFER_BYTES);
                        if (int'(size_total) + BLOCK_BYTES >= BUFFER_BYTES)
                            size_total = 17'(BUFFER_BYTES);
                        else
                            size_total = size_total + 17'(BLOCK_BYTES);
                        push_word(KIND_SEND, CH_ACK, '0, '0, 1'b1);
                    end
                end
                default:
                begin
                    // header byte: end, cancel, start of block or stray
                    tick_count = '0;
                    if (value == CH_EOT)
                    begin
                        push_word(KIND_SEND, CH_ACK, '0, '0, 1'b0);
                        push_word(KIND_FINISH, '0, '0, '0, 1'b1);
                        restart_transfer();
                    end
                    else if (value == CH_CAN)
                    begin
                        push_word(KIND_ABORT, '0, '0, '0, 1'b1);
                        restart_transfer();
                    end
                    else if (value == CH_SOH)
                    begin
                        in_transfer = 1'b1;
                        rcv_phase   = GET_NUMBER;
                    end
                    else if (in_transfer)
                    begin
                        push_word(KIND_ABORT, '0, '0, '0, 1'b1);
                        restart_transfer();
                    end
                end
            endcase
        end
    endtask

    // -----------------------------------------------------------------------
    // Input side
    // -----------------------------------------------------------------------
    // Offer one word in bursts with random gaps; called and returns at a
    // falling edge. Expectations come from the table when use_table is set.
    task automatic drive_word(input logic op, input logic [7:0] value,
                              input bit use_table = 1'b0);
        int gap;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap != 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= value;
        s_axis_tuser  <= op;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_receiver_words(op, value);
        if (use_table)
            foreach (table_words[i])
                due_words.push_back(table_words[i]);
        else
            foreach (step_words[i])
                due_words.push_back(step_words[i]);
        if (op == 1'b0)
            byte_count++;
        @(negedge clk);
    endtask

    // Write the NAK interval once every pending word has left the block
    task automatic set_interval(input logic [21:0] value);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (due_words.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        nak_ticks = value;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [7:0] pick_data_byte();
        case ($urandom_range(0, 9))
            0:       return 8'h00;
            1:       return 8'hff;
            2:       return CH_SOH;
            3:       return CH_EOT;
            4:       return CH_CAN;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic send_ticks(input int count);
        repeat (count)
            drive_word(1'b1, 8'($urandom_range(0, 255)));
    endtask

    // Send one block built on the expected number, damaged as asked
    task automatic send_block(input block_flaw_t flaw);
        logic [7:0] number;
        logic [7:0] flip;
        logic [7:0] sum;
        logic [7:0] data;
        int         count;
        flip   = 8'($urandom_range(1, 255));
        number = next_block;
        if (flaw == FLAW_NUMBER)
            number = number ^ flip;
        drive_word(1'b0, CH_SOH);
        drive_word(1'b0, number);
        if (flaw != FLAW_NUMBER)
        begin
            drive_word(1'b0, (flaw == FLAW_INVERSE) ? (~number ^ flip) : ~number);
            if (flaw != FLAW_INVERSE)
            begin
                count = (flaw == FLAW_SHORT) ? $urandom_range(1, BLOCK_BYTES - 1)
                                             : BLOCK_BYTES;
                sum = '0;
                repeat (count)
                begin
                    data = pick_data_byte();
                    sum  = sum + data;
                    drive_word(1'b0, data);
                end
                if (flaw != FLAW_SHORT)
                    drive_word(1'b0, (flaw == FLAW_SUM) ? (sum ^ flip) : sum);
            end
        end
    endtask

    // Mostly well-formed blocks, with damaged blocks, control bytes and noise
    task automatic run_mixed_traffic(input int items);
        int target;
        int sel;
        target = byte_count + items;
        while (byte_count < target)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 55)
                send_block(FLAW_NONE);
            else if (sel < 63)
                send_block(FLAW_SUM);
            else if (sel < 68)
                send_block(FLAW_NUMBER);
            else if (sel < 72)
                send_block(FLAW_INVERSE);
            else if (sel < 76)
                send_block(FLAW_SHORT);
            else if (sel < 83)
                send_ticks($urandom_range(1, 10));
            else if (sel < 88)
                drive_word(1'b0, CH_EOT);
            else if (sel < 91)
                drive_word(1'b0, CH_CAN);
            else
                repeat ($urandom_range(1, 4))
                    drive_word(1'b0, pick_data_byte());
        end
    endtask

    task automatic add_cfg(input logic [21:0] value);
        script_row_t r;
        r.is_cfg      = 1'b1;
        r.interval    = value;
        r.op          = 1'b0;
        r.value       = '0;
        r.word_count  = 0;
        r.first_kind  = KIND_SEND;
        r.first_tx    = '0;
        r.second_kind = KIND_SEND;
        directed_rows.push_back(r);
    endtask

    task automatic add_item(input logic op, input logic [7:0] value, input int n,
                            input kind_t k0 = KIND_SEND, input logic [7:0] tx0 = '0,
                            input kind_t k1 = KIND_SEND);
        script_row_t r;
        r.is_cfg      = 1'b0;
        r.interval    = '0;
        r.op          = op;
        r.value       = value;
        r.word_count  = n;
        r.first_kind  = k0;
        r.first_tx    = tx0;
        r.second_kind = k1;
        directed_rows.push_back(r);
    endtask

    // -----------------------------------------------------------------------
    // Stimulus
    // -----------------------------------------------------------------------
    initial
    begin
        rx_word_t w;
        int       good_blocks;
        bit       bad;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        nak_ticks = NAK_INTERVAL_RESET;
        restart_transfer();
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Ticks and stray bytes under the reset interval, control bytes idle
        add_item(1'b1, 8'hff, 0);
        add_item(1'b0, 8'h00, 0);
        add_item(1'b0, 8'hff, 0);
        add_item(1'b0, CH_CAN, 1, KIND_ABORT);
        add_item(1'b0, CH_EOT, 2, KIND_SEND, CH_ACK, KIND_FINISH);
        // NAK on every tick at the shortest intervals
        add_cfg(22'd1);
        add_item(1'b1, 8'h00, 1, KIND_SEND, CH_NAK);
        add_item(1'b1, 8'hff, 1, KIND_SEND, CH_NAK);
        add_cfg(22'd0);
        add_item(1'b1, 8'h5a, 1, KIND_SEND, CH_NAK);
        // A received byte restarts the tick count
        add_cfg(22'd3);
        add_item(1'b1, 8'h00, 0);
        add_item(1'b1, 8'h00, 0);
        add_item(1'b0, 8'h55, 0);
        add_item(1'b1, 8'h00, 0);
        add_item(1'b1, 8'h00, 0);
        add_item(1'b1, 8'h00, 1, KIND_SEND, CH_NAK);
        // Wrong block number; ticks inside a transfer are dropped
        add_item(1'b0, CH_SOH, 0);
        add_item(1'b1, 8'h00, 0);
        add_item(1'b0, 8'h02, 1, KIND_SEND, CH_NAK);
        add_item(1'b1, 8'h00, 0);
        // Wrong inverted number, then a stray header byte aborts
        add_item(1'b0, CH_SOH, 0);
        add_item(1'b0, 8'h01, 0);
        add_item(1'b0, 8'h00, 1, KIND_SEND, CH_NAK);
        add_item(1'b0, 8'h33, 1, KIND_ABORT);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].is_cfg)
                set_interval(directed_rows[i].interval);
            else
            begin
                table_words.delete();
                w.kind       = KIND_SEND;
                w.tx_byte    = '0;
                w.store_addr = '0;
                w.store_data = '0;
                w.total_size = '0;
                w.last       = 1'b0;
                if (directed_rows[i].word_count > 0)
                begin
                    w.kind    = directed_rows[i].first_kind;
                    w.tx_byte = directed_rows[i].first_tx;
                    w.last    = (directed_rows[i].word_count == 1);
                    table_words.push_back(w);
                end
                if (directed_rows[i].word_count > 1)
                begin
                    w.kind    = directed_rows[i].second_kind;
                    w.tx_byte = '0;
                    w.last    = 1'b1;
                    table_words.push_back(w);
                end
                drive_word(directed_rows[i].op, directed_rows[i].value,
                           directed_rows[i].word_count >= 0);
            end
        end

        // Random traffic under two short intervals
        set_interval(22'($urandom_range(1, 4)));
        run_mixed_traffic(100);
        set_interval(22'($urandom_range(5, 12)));
        run_mixed_traffic(100);
        // finish any partial block, then close the transfer
        while (rcv_phase != WAIT_HEADER)
            drive_word(1'b0, pick_data_byte());
        drive_word(1'b0, CH_EOT);

        // Transfer at the widest interval with a long result-side hold-off
        set_interval(22'h3fffff);
        send_ticks($urandom_range(1, 5));
        good_blocks = 0;
        while (good_blocks < 2)
        begin
            // stall the result side mid-transfer so the input backs up
            if (good_blocks == 1 && !bad)
                hold_req = 1'b1;
            bad = ($urandom_range(0, 7) == 0);
            send_block(bad ? FLAW_SUM : FLAW_NONE);
            if (!bad)
                good_blocks++;
        end
        drive_word(1'b0, CH_EOT);

        // Drain and report
        s_axis_tvalid <= 1'b0;
        while (due_words.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (failures == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Result side: stall pattern, with one long hold-off on request
    // -----------------------------------------------------------------------
    initial
    begin
        rx_mode_t mode;
        int       mode_left;
        int       beat;
        mode      = RX_ALWAYS;
        mode_left = 0;
        beat      = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode      = rx_mode_t'($urandom_range(0, 3));
                    mode_left = $urandom_range(10, 60);
                end
                mode_left--;
                beat++;
                case (mode)
                    RX_ALWAYS:  m_axis_tready <= 1'b1;
                    RX_PATTERN: m_axis_tready <= !((beat % 5 == 2) || (beat % 7 == 0));
                    RX_RANDOM:  m_axis_tready <= 1'($urandom_range(0, 1));
                    default:    m_axis_tready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // -----------------------------------------------------------------------
    // Checker
    // -----------------------------------------------------------------------
    task automatic report_field(input string name, input logic [16:0] want,
                                input logic [16:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
                     $time, name, want, got);
            failures++;
        end
    endtask

    always @(posedge clk)
    begin
        rx_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (due_words.size() == 0)
            begin
                $display("%0t: unexpected word, expected none, actual kind %0d tdata 0x%0h",
                         $time, m_axis_tuser, m_axis_tdata);
                failures++;
            end
            else
            begin
                want = due_words.pop_front();
                report_field("kind", 17'(want.kind), 17'(m_axis_tuser));
                report_field("tx_byte", 17'(want.tx_byte), 17'(m_axis_tdata[7:0]));
                report_field("store_addr", 17'(want.store_addr), 17'(m_axis_tdata[23:8]));
                report_field("store_data", 17'(want.store_data), 17'(m_axis_tdata[31:24]));
                report_field("total_size", want.total_size, m_axis_tdata[48:32]);
                report_field("last", 17'(want.last), 17'(m_axis_tlast));
            end
        end
    end

    // Hard stop in case the handshakes hang
    initial
    begin
        #(LIMIT_NS);
        $display("Test completed with failures");
        $finish;
    end

endmodule

// File: files.f
+incdir+design
design/xmck_pkg.sv
design/xmck_proto.sv
design/xmck_outq.sv
design/xmodem_checksum_receiver.sv
design/xmck_checker.sv
tb/xmodem_checksum_receiver_tb.sv
